/* src/wildcard_byte_pattern_scan_assert.svh */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan - assertion macros
// Concurrent checks on the scan control, clocked by i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WBPS_ASSERT_SAME(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("wbps: check failed");
`define WBPS_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("wbps: check failed");
`else
`define WBPS_ASSERT_SAME(label, ant, cons)
`define WBPS_ASSERT_NEXT(label, ant, cons)
`endif
`endif

/* src/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan - package
// Shared constants, types and compare functions.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int REG_PATTERN_BYTES = 16;
    localparam int PAT_CAP = (MAX_PATTERN < REG_PATTERN_BYTES) ? MAX_PATTERN
                                                               : REG_PATTERN_BYTES;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int REG_LEN_W = 5;
    localparam int BIDX_W = $clog2(REG_PATTERN_BYTES);
    localparam int COUNT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd3;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic  active;
        logic  care;
        t_byte pbyte;
    } t_pat_sel;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] offset;
    } t_result;

    function automatic t_pat_sel pat_select(
        input t_byte                        pat [REG_PATTERN_BYTES],
        input logic [REG_PATTERN_BYTES-1:0] care,
        input logic [LEN_W-1:0]             len,
        input int                           pos
    );
        t_pat_sel          sel;
        logic [LEN_W-1:0]  j;
        logic [BIDX_W-1:0] jx;
        j          = len - LEN_W'(pos) - LEN_W'(1);
        jx         = BIDX_W'(j);
        sel.active = LEN_W'(pos) < len;
        sel.care   = care[jx];
        sel.pbyte  = pat[jx];
        return sel;
    endfunction

    function automatic logic pos_ok(input t_byte b, input t_pat_sel sel);
        return !sel.active || !sel.care || (b == sel.pbyte);
    endfunction

endpackage

/* src/wbps_cell.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan - window cell
// Holds one window byte, passes it on each request, compares it masked.
// ----------------------------------------------------------------------------
module wbps_cell
    import wbps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_shift,
    input  t_byte    i_byte,
    input  t_pat_sel i_sel,
    output t_byte    o_byte,
    output logic     o_ok
);

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_ok   = pos_ok(r_byte, i_sel);

endmodule

/* src/wbps_outq.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan - result register with skid stage
// Two-deep output holding so the input side can push one more result under stall.
// ----------------------------------------------------------------------------
module wbps_outq
    import wbps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_take
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_out_valid && i_take;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            n_out_valid  = r_skid_valid || i_push;
            n_out        = r_skid_valid ? r_skid : i_res;
            n_skid_valid = r_skid_valid && i_push;
            n_skid       = i_res;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

/* src/wildcard_byte_pattern_scan.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan - top level
// Takes one byte per cycle and reports the first masked pattern match in an
// image, or a not-found result at its last byte. The byte window is a row of
// cells that shift on every request and compare in parallel with the pattern;
// the result goes into the result register or, under stall, the skid stage
// behind it. The input is ready whenever the skid stage is empty, so one byte
// per cycle is sustained unless the master side stalls with two results held.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_assert.svh"

module wildcard_byte_pattern_scan
    import wbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] image_byte
    input  logic                  s_axis_tlast,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [COUNT_W-1:0]    m_axis_tdata,   // [31:0] match_offset
    output logic                  m_axis_tuser    // found
);

    logic [CFG_DATA_W-1:0]        r_pat_lo;
    logic [CFG_DATA_W-1:0]        r_pat_hi;
    logic [REG_PATTERN_BYTES-1:0] r_care;
    logic [REG_LEN_W-1:0]         r_len;
    logic [COUNT_W-1:0]           r_seen, n_seen;
    logic                         r_reported;

    t_byte                        pat [REG_PATTERN_BYTES];
    logic [LEN_W-1:0]             eff_len;
    t_byte                        cur [MAX_PATTERN];
    t_pat_sel                     sel [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]       ok;
    logic                         in_acc;
    logic                         hit;
    logic                         push;
    t_result                      res;
    t_result                      out_res;
    logic                         q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '1;
            r_len    <= REG_LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAT_LOW:  r_pat_lo <= i_cfg_data;
                REG_PAT_HIGH: r_pat_hi <= i_cfg_data;
                REG_CARE:     r_care   <= i_cfg_data[REG_PATTERN_BYTES-1:0];
                REG_LENGTH:   r_len    <= i_cfg_data[REG_LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < REG_PATTERN_BYTES / 2; i++) begin
            pat[i]                         = r_pat_lo[8*i +: 8];
            pat[i + REG_PATTERN_BYTES / 2] = r_pat_hi[8*i +: 8];
        end
    end

    always_comb begin
        priority if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > REG_LEN_W'(PAT_CAP)) begin
            eff_len = LEN_W'(PAT_CAP);
        end else begin
            eff_len = LEN_W'(r_len);
        end
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cur[0] = s_axis_tdata;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_pos
            assign sel[k] = pat_select(pat, r_care, eff_len, k);
        end
        for (k = 1; k < MAX_PATTERN; k++) begin : g_cell
            wbps_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (in_acc),
                .i_byte  (cur[k-1]),
                .i_sel   (sel[k]),
                .o_byte  (cur[k]),
                .o_ok    (ok[k])
            );
        end
    endgenerate

    assign ok[0] = pos_ok(cur[0], sel[0]);

    assign n_seen = (r_seen == '1) ? r_seen : r_seen + COUNT_W'(1);
    assign hit    = !r_reported && (n_seen >= COUNT_W'(eff_len)) && (&ok);

    always_comb begin
        res.found  = hit;
        res.offset = hit ? n_seen - COUNT_W'(eff_len) : '0;
    end

    assign push = in_acc && (hit || (s_axis_tlast && !r_reported));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (in_acc) begin
            if (s_axis_tlast) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else begin
                r_seen     <= n_seen;
                r_reported <= r_reported || hit;
            end
        end
    end

    wbps_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res),
        .o_ready (q_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_take  (m_axis_tready)
    );

    assign s_axis_tready = q_ready;
    assign m_axis_tdata  = out_res.offset;
    assign m_axis_tuser  = out_res.found;

    `WBPS_ASSERT_NEXT(a_clear_on_last, in_acc && s_axis_tlast, r_seen == '0 && !r_reported)
    `WBPS_ASSERT_SAME(a_reported_has_count, r_reported, r_seen != '0)
    `WBPS_ASSERT_NEXT(a_hit_sets_reported, in_acc && hit && !s_axis_tlast, r_reported)
    `WBPS_ASSERT_SAME(a_no_hit_after_report, r_reported, !hit)

endmodule
